>>> rtl/gta_pkg.sv
// Package for the GEMM tile accumulator: field widths, register indexes,
// and the snapshot and control types that pass between the cells and the sequencer.
// Has no dependencies.
package gta_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int IDX_W      = 2;
    localparam int USE_W      = 4;
    localparam int CNT_CFG_W  = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int TILE_ROWS_DEF = 4;
    localparam int TILE_COLS_DEF = 4;

    typedef enum logic [1:0] {
        REG_BETA = 2'd0,
        REG_ROWS = 2'd1,
        REG_COLS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] value;
    } snap_t;

    typedef struct packed {
        logic             prod_load;
        logic             scale_mul;
        logic             scale_load;
        logic             acc_add;
        logic             snap_load;
        logic             snap_shift;
        logic [USE_W-1:0] nr;
        logic [USE_W-1:0] nc;
    } cell_ctrl_t;

endpackage

>>> rtl/gta_cfg.sv
// Configuration registers of the GEMM tile accumulator behind an APB-style port.
// Depends on gta_pkg.
module gta_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gta_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [gta_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [gta_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic signed [gta_pkg::DATA_W-1:0] beta,
    output logic [gta_pkg::CNT_CFG_W-1:0]    rows_in_use,
    output logic [gta_pkg::CNT_CFG_W-1:0]    cols_in_use
);

    logic signed [gta_pkg::DATA_W-1:0] beta_reg;
    logic [gta_pkg::CNT_CFG_W-1:0]     rows_reg;
    logic [gta_pkg::CNT_CFG_W-1:0]     cols_reg;
    gta_pkg::reg_idx_t                 idx;
    logic                              wr_en;

    assign pready = 1'b1;
    assign idx    = gta_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= '0;
            rows_reg <= gta_pkg::CNT_CFG_W'(4);
            cols_reg <= gta_pkg::CNT_CFG_W'(4);
        end else if (wr_en) begin
            unique case (idx)
                gta_pkg::REG_BETA: beta_reg <= pwdata[gta_pkg::DATA_W-1:0];
                gta_pkg::REG_ROWS: rows_reg <= pwdata[gta_pkg::CNT_CFG_W-1:0];
                gta_pkg::REG_COLS: cols_reg <= pwdata[gta_pkg::CNT_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            gta_pkg::REG_BETA: prdata = beta_reg;
            gta_pkg::REG_ROWS: prdata = gta_pkg::CFG_DATA_W'(rows_reg);
            gta_pkg::REG_COLS: prdata = gta_pkg::CFG_DATA_W'(cols_reg);
            default:           prdata = '0;
        endcase
    end

    assign beta        = beta_reg;
    assign rows_in_use = rows_reg;
    assign cols_in_use = cols_reg;

endmodule

>>> rtl/gta_cell.sv
// One accumulator cell: product register, beta scaling in two steps, saturating add,
// and one stage of the snapshot chain that carries the tile to the output. Depends on gta_pkg.
module gta_cell #(
    parameter int ROW = 0,
    parameter int COL = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gta_pkg::cell_ctrl_t               ctrl,
    input  logic signed [gta_pkg::DATA_W-1:0] beta,
    input  logic signed [gta_pkg::DATA_W-1:0] a_val,
    input  logic signed [gta_pkg::DATA_W-1:0] b_val,
    input  gta_pkg::snap_t                    snap_in,
    output gta_pkg::snap_t                    snap_out
);

    localparam int ACC_W = gta_pkg::ACC_W;
    localparam int SCL_W = ACC_W + 16;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] pp_hi_reg, pp_hi_next;
    logic signed [ACC_W:0]   pp_lo_reg, pp_lo_next;
    logic signed [SCL_W-1:0] scaled;
    logic signed [ACC_W-1:0] scaled_sat;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sum_sat;
    gta_pkg::snap_t          snap_reg, snap_next;
    logic                    here_valid;
    logic                    here_last;

    always_comb begin
        prod_next  = a_val * b_val;
        pp_hi_next = $signed(acc_reg[ACC_W-1:32]) * beta;
        pp_lo_next = $signed({1'b0, acc_reg[31:0]}) * $signed({beta[gta_pkg::DATA_W-1], beta});

        scaled = $signed({pp_hi_reg, 16'h0000}) + SCL_W'(pp_lo_reg >>> 16);
        if ((&scaled[SCL_W-1:ACC_W-1]) || !(|scaled[SCL_W-1:ACC_W-1])) begin
            scaled_sat = scaled[ACC_W-1:0];
        end else begin
            scaled_sat = scaled[SCL_W-1] ? ACC_MIN : ACC_MAX;
        end

        sum = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum[ACC_W-1:0];
        end

        if (ctrl.scale_load) begin
            acc_next = scaled_sat;
        end else if (ctrl.acc_add) begin
            acc_next = sum_sat;
        end else begin
            acc_next = acc_reg;
        end

        here_valid = (gta_pkg::USE_W'(ROW) < ctrl.nr) && (gta_pkg::USE_W'(COL) < ctrl.nc);
        here_last  = (gta_pkg::USE_W'(ROW) == ctrl.nr - 1'b1)
                  && (gta_pkg::USE_W'(COL) == ctrl.nc - 1'b1);

        if (ctrl.snap_load) begin
            snap_next.valid = here_valid;
            snap_next.last  = here_last;
            snap_next.row   = gta_pkg::IDX_W'(ROW);
            snap_next.col   = gta_pkg::IDX_W'(COL);
            snap_next.value = acc_next;
        end else if (ctrl.snap_shift) begin
            snap_next = snap_in;
        end else begin
            snap_next = snap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            snap_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            snap_reg <= snap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.prod_load) begin
            prod_reg <= prod_next;
        end
        if (ctrl.scale_mul) begin
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
        end
    end

    assign snap_out = snap_reg;

endmodule

>>> rtl/gta_seq.sv
// Sequencer of the GEMM tile accumulator: holds the request in the product stage,
// steps the beta scaling and decides when the cells add and load the snapshot chain.
// Depends on gta_pkg.
module gta_seq #(
    parameter int TILE_ROWS = gta_pkg::TILE_ROWS_DEF,
    parameter int TILE_COLS = gta_pkg::TILE_COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          cmd_in,
    input  logic                          first_in,
    input  logic                          chain_empty,
    input  logic                          out_take,
    input  logic [gta_pkg::CNT_CFG_W-1:0] rows_in_use,
    input  logic [gta_pkg::CNT_CFG_W-1:0] cols_in_use,
    output logic                          s_tready,
    output gta_pkg::cell_ctrl_t           ctrl
);

    typedef enum logic [1:0] {
        PH_MUL,
        PH_SCALE,
        PH_ADD
    } phase_t;

    localparam logic [gta_pkg::USE_W-1:0] NR_MAX = gta_pkg::USE_W'(TILE_ROWS);
    localparam logic [gta_pkg::USE_W-1:0] NC_MAX = gta_pkg::USE_W'(TILE_COLS);

    phase_t                    phase_reg;
    logic                      p_valid_reg;
    logic                      p_cmd_reg;
    logic                      p_first_reg;
    logic [gta_pkg::USE_W-1:0] rows_ext;
    logic [gta_pkg::USE_W-1:0] cols_ext;

    assign rows_ext = gta_pkg::USE_W'(rows_in_use);
    assign cols_ext = gta_pkg::USE_W'(cols_in_use);

    always_comb begin
        ctrl.scale_mul  = p_valid_reg && p_first_reg && (phase_reg == PH_MUL);
        ctrl.scale_load = p_valid_reg && (phase_reg == PH_SCALE);
        ctrl.acc_add    = p_valid_reg && (!p_first_reg || phase_reg == PH_ADD)
                       && (!p_cmd_reg || chain_empty);
        ctrl.snap_load  = ctrl.acc_add && p_cmd_reg;
        ctrl.snap_shift = out_take;
        ctrl.nr         = (rows_ext > NR_MAX) ? NR_MAX : rows_ext;
        ctrl.nc         = (cols_ext > NC_MAX) ? NC_MAX : cols_ext;
        s_tready        = !p_valid_reg || ctrl.acc_add;
        ctrl.prod_load  = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MUL;
            p_valid_reg <= 1'b0;
            p_cmd_reg   <= 1'b0;
            p_first_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                p_valid_reg <= s_tvalid;
                p_cmd_reg   <= cmd_in;
                p_first_reg <= first_in;
            end
            unique case (phase_reg)
                PH_MUL: begin
                    if (ctrl.scale_mul) begin
                        phase_reg <= PH_SCALE;
                    end
                end
                PH_SCALE: begin
                    phase_reg <= PH_ADD;
                end
                PH_ADD: begin
                    if (ctrl.acc_add) begin
                        phase_reg <= PH_MUL;
                    end
                end
                default: begin
                    phase_reg <= PH_MUL;
                end
            endcase
        end
    end

    a_scale_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.scale_load |-> $past(ctrl.scale_mul))
        else $error("Scaled value loaded without a preceding partial product step.");

    a_snap_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.snap_load |-> (chain_empty && ctrl.acc_add))
        else $error("Snapshot chain loaded while still holding a tile.");

    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && !s_tready) |=> (p_valid_reg && $stable(p_cmd_reg)
                                        && $stable(p_first_reg)))
        else $error("Pending request lost while the input was stalled.");

endmodule

>>> rtl/gemm_tile_accumulator_unit.sv
// Top level of the GEMM tile accumulator: a chain of accumulator cells, the sequencer,
// the configuration registers and the output register. Depends on gta_pkg, gta_cfg,
// gta_cell and gta_seq.
//
// Each request on the s_ channel is one k-step: TILE_ROWS A values and TILE_COLS B
// values in s_tdata, with the emit command and the tile-start flag in s_tuser. Every
// cell multiplies its A and B values into a product register, and then adds that register
// into its saturating Q32.32 accumulator. Plain steps can be accepted back to back. A tile-start
// step stalls the input, because beta scaling first forms partial products and then combines
// and saturates them before the add. An emit step copies the updated tile into the snapshot
// chain; the chain hands one element per cycle to the output register while the receiver
// takes them, column by column, and elements of unused rows and columns are not sent out.
// After a plain emit step is accepted, its first element passes from the product register
// through the snapshot chain into the output register. A further emit step waits until
// the chain has drained, while non-emit steps continue meanwhile.
// When the receiver stalls, the output register and the chain hold their contents.
// Reset clears the accumulators, the chain and the output valid flag, and sets beta to zero and
// the rows and columns in use to four. Configuration is written through the APB port.
module gemm_tile_accumulator_unit #(
    parameter int TILE_ROWS = gta_pkg::TILE_ROWS_DEF,
    parameter int TILE_COLS = gta_pkg::TILE_COLS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [gta_pkg::CFG_ADDR_W-1:0]               paddr,
    input  logic [gta_pkg::CFG_DATA_W-1:0]               pwdata,
    output logic [gta_pkg::CFG_DATA_W-1:0]               prdata,
    output logic                                         pready,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // a_row0 .. a_row(TILE_ROWS-1), then b_col0 .. b_col(TILE_COLS-1), 32 bits each.
    input  logic [gta_pkg::DATA_W*(TILE_ROWS+TILE_COLS)-1:0] s_tdata,
    // Bit 0 command, bit 1 first.
    input  logic [1:0]                                   s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // Bits 63:0 value.
    output logic [gta_pkg::ACC_W-1:0]                    m_tdata,
    // Bits 1:0 row, bits 3:2 col.
    output logic [2*gta_pkg::IDX_W-1:0]                  m_tuser,
    output logic                                         m_tlast
);

    localparam int CELLS  = TILE_ROWS * TILE_COLS;
    localparam int DATA_W = gta_pkg::DATA_W;

    logic signed [DATA_W-1:0]          beta;
    logic [gta_pkg::CNT_CFG_W-1:0]     rows_in_use;
    logic [gta_pkg::CNT_CFG_W-1:0]     cols_in_use;
    gta_pkg::cell_ctrl_t               ctrl;
    gta_pkg::snap_t                    snap [CELLS];
    logic                              chain_empty;
    logic                              out_take;
    logic                              m_valid_reg;
    logic                              m_last_reg;
    logic [gta_pkg::IDX_W-1:0]         m_row_reg;
    logic [gta_pkg::IDX_W-1:0]         m_col_reg;
    logic [gta_pkg::ACC_W-1:0]         m_value_reg;

    gta_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .beta        (beta),
        .rows_in_use (rows_in_use),
        .cols_in_use (cols_in_use)
    );

    gta_seq #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .cmd_in      (s_tuser[0]),
        .first_in    (s_tuser[1]),
        .chain_empty (chain_empty),
        .out_take    (out_take),
        .rows_in_use (rows_in_use),
        .cols_in_use (cols_in_use),
        .s_tready    (s_tready),
        .ctrl        (ctrl)
    );

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        localparam int R = i % TILE_ROWS;
        localparam int C = i / TILE_ROWS;
        gta_pkg::snap_t snap_in;

        if (i == CELLS - 1) begin : g_tail
            assign snap_in = '0;
        end else begin : g_link
            assign snap_in = snap[i+1];
        end

        gta_cell #(
            .ROW (R),
            .COL (C)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .beta     (beta),
            .a_val    (s_tdata[DATA_W*R +: DATA_W]),
            .b_val    (s_tdata[DATA_W*(TILE_ROWS+C) +: DATA_W]),
            .snap_in  (snap_in),
            .snap_out (snap[i])
        );
    end

    always_comb begin
        chain_empty = 1'b1;
        for (int i = 0; i < CELLS; i++) begin
            if (snap[i].valid) begin
                chain_empty = 1'b0;
            end
        end
    end

    assign out_take = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= snap[0].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            m_last_reg  <= snap[0].last;
            m_row_reg   <= snap[0].row;
            m_col_reg   <= snap[0].col;
            m_value_reg <= snap[0].value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> sim/gemm_tile_accumulator_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gemm_tile_accumulator_unit: directed and random k-step requests
// are checked element by element against a fixed-point tile predictor.
// Depends on gta_pkg and the gemm_tile_accumulator_unit RTL.
module gemm_tile_accumulator_unit_tb;

    localparam int TILE_DIM        = 4;
    localparam int NUM_DIRECTED    = 18;
    localparam int NUM_PHASES      = 8;
    localparam int STEPS_PER_PHASE = 25;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last;
    } tile_elem_t;

    typedef struct packed {
        logic         cfg_wr;
        logic [31:0]  beta;
        logic [2:0]   rows;
        logic [2:0]   cols;
        logic         cmd;
        logic         first;
        logic [127:0] a;
        logic [127:0] b;
        logic         typed;
        logic [63:0]  value;
    } step_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    longint      tile_acc [TILE_DIM*TILE_DIM];
    logic [31:0] beta_q;
    logic [2:0]  rows_q;
    logic [2:0]  cols_q;
    tile_elem_t  pending_elems [$];
    tile_elem_t  want;
    step_row_t   directed_steps [NUM_DIRECTED];
    bit          quiet = 1'b0;
    int          errors = 0;
    int          idle_cycles = 0;

    gemm_tile_accumulator_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint scale_by_beta(longint acc, logic [31:0] beta);
        logic signed [95:0] acc_w;
        logic signed [95:0] beta_w;
        logic signed [95:0] scaled;
        acc_w  = acc;
        beta_w = $signed(beta);
        scaled = (acc_w * beta_w) >>> 16;
        if (scaled > ACC_MAX) return ACC_MAX;
        if (scaled < ACC_MIN) return ACC_MIN;
        return longint'(scaled[63:0]);
    endfunction

    function automatic longint add_saturated(longint x, longint y);
        logic signed [64:0] sum;
        sum = 65'(x) + 65'(y);
        if (sum > ACC_MAX) return ACC_MAX;
        if (sum < ACC_MIN) return ACC_MIN;
        return longint'(sum[63:0]);
    endfunction

    function automatic void predict_tile(logic cmd, logic first, logic [127:0] a,
                                         logic [127:0] b, logic typed, logic [63:0] value);
        int nr;
        int nc;
        tile_elem_t e;
        if (first) begin
            for (int i = 0; i < TILE_DIM*TILE_DIM; i++)
                tile_acc[i] = scale_by_beta(tile_acc[i], beta_q);
        end
        for (int r = 0; r < TILE_DIM; r++)
            for (int c = 0; c < TILE_DIM; c++)
                tile_acc[r*TILE_DIM+c] = add_saturated(tile_acc[r*TILE_DIM+c],
                    longint'(signed'(a[32*r +: 32])) * longint'(signed'(b[32*c +: 32])));
        if (!cmd) return;
        nr = (rows_q > TILE_DIM) ? TILE_DIM : rows_q;
        nc = (cols_q > TILE_DIM) ? TILE_DIM : cols_q;
        for (int c = 0; c < nc; c++)
            for (int r = 0; r < nr; r++) begin
                e.value = typed ? value : tile_acc[r*TILE_DIM+c];
                e.row   = r[1:0];
                e.col   = c[1:0];
                e.last  = (c == nc - 1) && (r == nr - 1);
                pending_elems.push_back(e);
            end
    endfunction

    function automatic logic [31:0] rand_q16();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
        if (pick < 8) return $urandom;
        return (pick == 8) ? Q_MAX : Q_MIN;
    endfunction

    task automatic apb_write(gta_pkg::reg_idx_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            gta_pkg::REG_BETA: beta_q = data;
            gta_pkg::REG_ROWS: rows_q = data[2:0];
            gta_pkg::REG_COLS: cols_q = data[2:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [31:0] beta, logic [2:0] rows, logic [2:0] cols);
        apb_write(gta_pkg::REG_BETA, beta);
        apb_write(gta_pkg::REG_ROWS, {29'd0, rows});
        apb_write(gta_pkg::REG_COLS, {29'd0, cols});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_elems.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_step(logic cmd, logic first, logic [127:0] a, logic [127:0] b,
                             logic typed, logic [63:0] value);
        while (!quiet && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= {first, cmd};
        do @(posedge aclk); while (!s_tready);
        predict_tile(cmd, first, a, b, typed, value);
        @(negedge aclk);
    endtask

    always @(negedge aclk) m_tready <= quiet || ($urandom_range(0, 99) >= 17);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                errors++;
                $display("%0t: result without request: expected none, actual value %h",
                         $time, m_tdata);
            end else begin
                want = pending_elems.pop_front();
                if (m_tdata !== want.value) begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
                end
                if (m_tuser[1:0] !== want.row) begin
                    errors++;
                    $display("%0t: row expected %0d actual %0d", $time, want.row, m_tuser[1:0]);
                end
                if (m_tuser[3:2] !== want.col) begin
                    errors++;
                    $display("%0t: col expected %0d actual %0d", $time, want.col, m_tuser[3:2]);
                end
                if (m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gemm_tile_accumulator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [127:0] a;
        logic [127:0] b;
        logic         cmd;
        logic         first;
        logic [31:0]  beta;
        int           sent;
        int           k;

        // Columns: cfg_wr, beta, rows, cols, cmd, first, a, b, typed, value.
        directed_steps = '{
            '{1'b0, '0, 3'd4, 3'd4, 1'b1, 1'b0, '0, '0, 1'b1, 64'h0},
            '{1'b0, '0, 3'd4, 3'd4, 1'b1, 1'b1, {4{Q_MIN}}, {4{Q_MIN}},
              1'b1, 64'h4000_0000_0000_0000},
            '{1'b0, '0, 3'd4, 3'd4, 1'b1, 1'b0, {4{Q_MIN}}, {4{Q_MIN}},
              1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
            '{1'b0, '0, 3'd4, 3'd4, 1'b0, 1'b1, {4{Q_MIN}}, {4{Q_MAX}}, 1'b0, '0},
            '{1'b0, '0, 3'd4, 3'd4, 1'b0, 1'b0, {4{Q_MIN}}, {4{Q_MAX}}, 1'b0, '0},
            '{1'b0, '0, 3'd4, 3'd4, 1'b1, 1'b0, {4{Q_MIN}}, {4{Q_MAX}},
              1'b1, 64'h8000_0000_0000_0000},
            '{1'b0, '0, 3'd4, 3'd4, 1'b1, 1'b0,
              {32'hFFFF_FFFF, 32'h0000_0001, Q_MIN, Q_MAX},
              {Q_NEG_ONE, Q_ONE, Q_MIN, Q_MAX}, 1'b0, '0},
            '{1'b1, Q_ONE, 3'd4, 3'd4, 1'b1, 1'b1,
              {32'h0001_8000, 32'hFFFE_8000, 32'h1234_5678, 32'hEDCB_A988},
              {32'h0000_0003, 32'hFFFF_FFFD, 32'h0002_0000, 32'h0000_8000}, 1'b0, '0},
            '{1'b1, Q_NEG_ONE, 3'd4, 3'd4, 1'b1, 1'b1, '0, '0, 1'b0, '0},
            '{1'b1, Q_MAX, 3'd1, 3'd1, 1'b1, 1'b1, '0, '0, 1'b0, '0},
            '{1'b1, Q_MIN, 3'd3, 3'd2, 1'b1, 1'b1,
              {32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0007, 32'hFFFF_FFF9},
              {32'h0000_0010, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0001}, 1'b0, '0},
            '{1'b1, Q_HALF, 3'd0, 3'd4, 1'b1, 1'b1, {4{32'hFFFF_FFFF}}, {4{32'h0000_0001}},
              1'b0, '0},
            '{1'b1, Q_HALF, 3'd4, 3'd0, 1'b1, 1'b1, '0, '0, 1'b0, '0},
            '{1'b1, Q_HALF, 3'd7, 3'd7, 1'b1, 1'b0, '0, '0, 1'b0, '0},
            '{1'b1, 32'h0001_8000, 3'd5, 3'd2, 1'b0, 1'b1, {4{Q_ONE}},
              {Q_NEG_ONE, Q_ONE, 32'h0000_0003, 32'hFFFF_FFFB}, 1'b0, '0},
            '{1'b0, '0, 3'd0, 3'd0, 1'b1, 1'b0,
              {Q_MAX, Q_MIN, 32'h0000_0001, 32'hFFFF_FFFF},
              {32'h0000_FFFF, 32'hFFFF_0001, Q_MAX, Q_MIN}, 1'b0, '0},
            '{1'b1, 32'h0001_8000, 3'd2, 3'd5, 1'b1, 1'b1, '0, '0, 1'b0, '0},
            '{1'b1, '0, 3'd4, 3'd4, 1'b1, 1'b1, '0, '0, 1'b1, 64'h0}
        };

        for (int i = 0; i < TILE_DIM*TILE_DIM; i++) tile_acc[i] = 0;
        beta_q = '0;
        rows_q = 3'd4;
        cols_q = 3'd4;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].cfg_wr) begin
                drain_results();
                configure(directed_steps[i].beta, directed_steps[i].rows,
                          directed_steps[i].cols);
            end
            send_step(directed_steps[i].cmd, directed_steps[i].first, directed_steps[i].a,
                      directed_steps[i].b, directed_steps[i].typed, directed_steps[i].value);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            quiet = (phase == 2);
            case ($urandom_range(0, 4))
                0: beta = '0;
                1: beta = Q_ONE;
                2: beta = Q_NEG_ONE;
                3: beta = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
                default: beta = $urandom;
            endcase
            configure(beta,
                      ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                 : 3'($urandom_range(0, 7)),
                      ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                 : 3'($urandom_range(0, 7)));
            sent = 0;
            while (sent < STEPS_PER_PHASE) begin
                k = $urandom_range(1, 6);
                for (int j = 0; j < k && sent < STEPS_PER_PHASE; j++) begin
                    first = (j == 0);
                    cmd   = (j == k - 1);
                    if ($urandom_range(0, 9) == 0) first = $urandom_range(0, 1);
                    if ($urandom_range(0, 9) == 0) cmd = !cmd;
                    for (int n = 0; n < TILE_DIM; n++) begin
                        a[32*n +: 32] = rand_q16();
                        b[32*n +: 32] = rand_q16();
                    end
                    // Hold the next request back until the whole tile has gone out.
                    if (phase == 4 && sent == 12) drain_results();
                    send_step(cmd, first, a, b, 1'b0, '0);
                    sent++;
                end
            end
        end
        quiet = 1'b0;
        drain_results();

        if (errors == 0)
            $display("gemm_tile_accumulator_unit: match");
        else
            $display("gemm_tile_accumulator_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/gta_pkg.sv
rtl/gta_cfg.sv
rtl/gta_cell.sv
rtl/gta_seq.sv
rtl/gemm_tile_accumulator_unit.sv
sim/gemm_tile_accumulator_unit_tb.sv
